[sv/assert_macros.svh]
// assertion macros for the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define CVBP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cvbp assertion failed");

// next-cycle implication, sampled on aclk, off during reset
`define CVBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cvbp assertion failed");

`endif

[sv/cvbp_pkg.sv]
// package: field limits, stage load struct and conversion functions
package cvbp_pkg;

    localparam int unsigned YEAR_MAX   = 99;
    localparam int unsigned MONTH_MAX  = 12;
    localparam int unsigned DAY_MAX    = 31;
    localparam int unsigned HOUR_MAX   = 23;
    localparam int unsigned MINUTE_MAX = 59;
    localparam int unsigned SECOND_MAX = 59;
    localparam int unsigned WKDAY_MAX  = 6;

    // weekday offset from the folded year base, mod 7
    localparam logic [2:0] WK_BASE = 3'd6;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } cvbp_adv_t;

    // (2m + 3(m+1)/5) mod 7, january and february as months 13 and 14
    function automatic logic [2:0] month_term(input logic [3:0] m);
        logic [2:0] t;
        case (m)
            4'd1:    t = 3'd6;
            4'd2:    t = 3'd2;
            4'd3:    t = 3'd1;
            4'd4:    t = 3'd4;
            4'd5:    t = 3'd6;
            4'd6:    t = 3'd2;
            4'd7:    t = 3'd4;
            4'd8:    t = 3'd0;
            4'd9:    t = 3'd3;
            4'd10:   t = 3'd5;
            4'd11:   t = 3'd1;
            4'd12:   t = 3'd3;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

    // packed bcd of a value 0..99, tens by reciprocal multiply
    function automatic logic [7:0] bin2bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [3:0]  ones;
        prod     = {8'd0, v} * 15'd205;
        tens     = prod[14:11];
        tens_x10 = {tens, 3'd0} + {2'd0, tens, 1'b0};
        ones     = 4'(v - tens_x10);
        return {tens, ones};
    endfunction

endpackage

[sv/cvbp_weekday.sv]
// three-stage weekday pipeline for years 2000 to 2099
module cvbp_weekday
    import cvbp_pkg::*;
(
    input  logic       aclk,
    input  cvbp_adv_t  adv,
    input  logic [6:0] year_in,
    input  logic [3:0] month_in,
    input  logic [5:0] day_in,
    output logic [2:0] weekday
);

    logic [6:0] z;
    logic [6:0] z_plus3;
    logic [6:0] p_next;
    logic [6:0] p_reg;
    logic [6:0] zq_next;
    logic [6:0] zq_reg;
    logic [7:0] sum;
    logic [6:0] fold_next;
    logic [6:0] fold_reg;
    logic [3:0] fold2;
    logic [2:0] wk_next;
    logic [2:0] wk_reg;

    // z is the year counted from 1999, after the jan/feb shift
    always_comb begin
        z         = (month_in <= 4'd2) ? year_in : 7'(year_in + 7'd1);
        z_plus3   = 7'(z + 7'd3);
        zq_next   = 7'(z + {2'd0, z_plus3[6:2]});
        p_next    = {1'b0, day_in} + {4'd0, month_term(month_in)} + {4'd0, WK_BASE};
    end

    // 64 = 1 mod 7
    always_comb begin
        sum       = {1'b0, p_reg} + {1'b0, zq_reg};
        fold_next = {5'd0, sum[7:6]} + {1'b0, sum[5:0]};
    end

    // 8 = 1 mod 7, then at most two subtractions
    always_comb begin
        fold2 = fold_reg[6:3] + {1'b0, fold_reg[2:0]};
        if (fold2 >= 4'd14) begin
            wk_next = 3'(fold2 - 4'd14);
        end else if (fold2 >= 4'd7) begin
            wk_next = 3'(fold2 - 4'd7);
        end else begin
            wk_next = fold2[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.ld1) begin
            p_reg  <= p_next;
            zq_reg <= zq_next;
        end
        if (adv.ld2) begin
            fold_reg <= fold_next;
        end
        if (adv.ld3) begin
            wk_reg <= wk_next;
        end
    end

    assign weekday = wk_reg;

endmodule

[sv/calendar_validate_bcd_pack.sv]
// top level: calendar record check, weekday and bcd packing pipeline
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | year, month, day, hour, minute, second, weekday
//  m_      | out       | m_valid / m_ready  | accepted, seven bcd bytes, weekday_out
//
// one beat in per cycle, one beat out per cycle when m_ready stays high
// the stages in order: check and month table; sum, fold and bcd; mod 7
// the stages hold their beat while the next stage is full and stalled
// aresetn clears the stage valid bits only
module calendar_validate_bcd_pack
    import cvbp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [6:0] s_year_in,
    input  logic [3:0] s_month_in,
    input  logic [5:0] s_day_in,
    input  logic [4:0] s_hour_in,
    input  logic [5:0] s_minute_in,
    input  logic [5:0] s_second_in,
    input  logic [2:0] s_weekday_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_accepted,
    output logic [7:0] m_second_bcd,
    output logic [7:0] m_minute_bcd,
    output logic [7:0] m_hour_bcd,
    output logic [7:0] m_day_bcd,
    output logic [7:0] m_weekday_bcd,
    output logic [7:0] m_month_bcd,
    output logic [7:0] m_year_bcd,
    output logic [2:0] m_weekday_out
);

    cvbp_adv_t  adv;
    logic       ready1;
    logic       ready2;
    logic       ready3;
    logic       ok_next;

    logic       v1_reg;
    logic       ok1_reg;
    logic [6:0] yr1_reg;
    logic [3:0] mo1_reg;
    logic [5:0] dy1_reg;
    logic [4:0] hr1_reg;
    logic [5:0] mi1_reg;
    logic [5:0] se1_reg;

    logic       v2_reg;
    logic       ok2_reg;
    logic [7:0] se2_reg;
    logic [7:0] mi2_reg;
    logic [7:0] hr2_reg;
    logic [7:0] dy2_reg;
    logic [7:0] mo2_reg;
    logic [7:0] yr2_reg;

    logic       v3_reg;
    logic       ok3_reg;
    logic [7:0] se3_reg;
    logic [7:0] mi3_reg;
    logic [7:0] hr3_reg;
    logic [7:0] dy3_reg;
    logic [7:0] mo3_reg;
    logic [7:0] yr3_reg;
    logic [2:0] wk;

    // stage load enables
    always_comb begin
        ready3  = !v3_reg || m_ready;
        ready2  = !v2_reg || ready3;
        ready1  = !v1_reg || ready2;
        adv.ld1 = ready1;
        adv.ld2 = ready2;
        adv.ld3 = ready3;
    end

    assign s_ready = ready1;

    always_comb begin
        ok_next = (32'(s_year_in) <= YEAR_MAX) &&
                  (s_month_in != 4'd0) && (32'(s_month_in) <= MONTH_MAX) &&
                  (s_day_in != 6'd0) && (32'(s_day_in) <= DAY_MAX) &&
                  (32'(s_hour_in) <= HOUR_MAX) &&
                  (32'(s_minute_in) <= MINUTE_MAX) &&
                  (32'(s_second_in) <= SECOND_MAX) &&
                  (32'(s_weekday_in) <= WKDAY_MAX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1) begin
            ok1_reg <= ok_next;
            yr1_reg <= s_year_in;
            mo1_reg <= s_month_in;
            dy1_reg <= s_day_in;
            hr1_reg <= s_hour_in;
            mi1_reg <= s_minute_in;
            se1_reg <= s_second_in;
        end
        if (ready2) begin
            ok2_reg <= ok1_reg;
            se2_reg <= ok1_reg ? bin2bcd({1'b0, se1_reg}) : 8'd0;
            mi2_reg <= ok1_reg ? bin2bcd({1'b0, mi1_reg}) : 8'd0;
            hr2_reg <= ok1_reg ? bin2bcd({2'd0, hr1_reg}) : 8'd0;
            dy2_reg <= ok1_reg ? bin2bcd({1'b0, dy1_reg}) : 8'd0;
            mo2_reg <= ok1_reg ? bin2bcd({3'd0, mo1_reg}) : 8'd0;
            yr2_reg <= ok1_reg ? bin2bcd(yr1_reg) : 8'd0;
        end
        if (ready3) begin
            ok3_reg <= ok2_reg;
            se3_reg <= se2_reg;
            mi3_reg <= mi2_reg;
            hr3_reg <= hr2_reg;
            dy3_reg <= dy2_reg;
            mo3_reg <= mo2_reg;
            yr3_reg <= yr2_reg;
        end
    end

    cvbp_weekday u_weekday (
        .aclk     (aclk),
        .adv      (adv),
        .year_in  (s_year_in),
        .month_in (s_month_in),
        .day_in   (s_day_in),
        .weekday  (wk)
    );

    assign m_valid       = v3_reg;
    assign m_accepted    = ok3_reg;
    assign m_second_bcd  = se3_reg;
    assign m_minute_bcd  = mi3_reg;
    assign m_hour_bcd    = hr3_reg;
    assign m_day_bcd     = dy3_reg;
    assign m_month_bcd   = mo3_reg;
    assign m_year_bcd    = yr3_reg;
    assign m_weekday_out = ok3_reg ? wk : 3'd0;
    assign m_weekday_bcd = {5'd0, m_weekday_out};

`include "assert_macros.svh"

    `CVBP_ASSERT_NOW(a_reject_zero, m_valid && !m_accepted, (m_second_bcd == 8'd0) && (m_minute_bcd == 8'd0) && (m_hour_bcd == 8'd0) && (m_day_bcd == 8'd0) && (m_month_bcd == 8'd0) && (m_year_bcd == 8'd0) && (m_weekday_out == 3'd0))
    `CVBP_ASSERT_NOW(a_weekday_range, m_valid && m_accepted, m_weekday_out <= 3'd6)
    `CVBP_ASSERT_NEXT(a_mid_stage_hold, v2_reg && !ready3, v2_reg && $stable(yr2_reg) && $stable(ok2_reg))
    `CVBP_ASSERT_NEXT(a_no_drop, v1_reg && !ready2, v1_reg && $stable(ok1_reg))

endmodule
